### design/array_element_address_assert.svh
// Assertion macros for the array element address block.
// Used by the port checker; needs nothing else.
`ifndef ARRAY_ELEMENT_ADDRESS_ASSERT_SVH
`define ARRAY_ELEMENT_ADDRESS_ASSERT_SVH

`define AEA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AEA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/aea_pkg.sv
// Shared types and constants for the array element address block.
// No dependencies.
package aea_pkg;

    localparam int unsigned AEA_DIMS_LIMIT = 3;
    localparam int unsigned AEA_IDX_W      = 8;

    localparam logic [AEA_IDX_W-1:0] REG_DIMS  = 8'd0;
    localparam logic [AEA_IDX_W-1:0] REG_ESIZE = 8'd1;
    localparam logic [AEA_IDX_W-1:0] REG_LO1   = 8'd2;
    localparam logic [AEA_IDX_W-1:0] REG_UP1   = 8'd3;
    localparam logic [AEA_IDX_W-1:0] REG_LO2   = 8'd4;
    localparam logic [AEA_IDX_W-1:0] REG_UP2   = 8'd5;
    localparam logic [AEA_IDX_W-1:0] REG_LO3   = 8'd6;
    localparam logic [AEA_IDX_W-1:0] REG_UP3   = 8'd7;

    localparam logic [1:0]  DIMS_RESET  = 2'd1;
    localparam logic [7:0]  ESIZE_RESET = 8'd8;

    typedef logic [AEA_DIMS_LIMIT-1:0][31:0] t_word_vec;

    typedef struct packed {
        logic [31:0]        base_address;
        logic [3:0]         subscript_count;
        logic signed [31:0] subscript_1;
        logic signed [31:0] subscript_2;
        logic signed [31:0] subscript_3;
    } t_aea_item;

    typedef struct packed {
        logic [31:0] elem_addr;
        logic        dims_mismatch;
    } t_aea_result;

    typedef struct packed {
        logic [1:0] dims;
        logic [7:0] esize;
        t_word_vec  lo;
        t_word_vec  len;
    } t_aea_cfg;

    typedef struct packed {
        logic        mismatch;
        logic [31:0] base;
        logic [31:0] acc;
        t_word_vec   diff;
    } t_aea_lane;

endpackage

### design/aea_cfg.sv
// Descriptor registers: dimension count, element size, bounds and lengths.
// Depends on aea_pkg.
module aea_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aea_pkg::AEA_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output aea_pkg::t_aea_cfg              o_cfg
);

    logic [1:0]         r_dims,  n_dims;
    logic [7:0]         r_esize, n_esize;
    aea_pkg::t_word_vec r_lo,    n_lo;
    aea_pkg::t_word_vec r_up,    n_up;
    aea_pkg::t_word_vec r_len,   n_len;

    always_comb begin
        n_dims  = r_dims;
        n_esize = r_esize;
        n_lo    = r_lo;
        n_up    = r_up;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                aea_pkg::REG_DIMS:  n_dims  = i_cfg_data[1:0];
                aea_pkg::REG_ESIZE: n_esize = i_cfg_data[7:0];
                aea_pkg::REG_LO1:   n_lo[0] = i_cfg_data;
                aea_pkg::REG_UP1:   n_up[0] = i_cfg_data;
                aea_pkg::REG_LO2:   n_lo[1] = i_cfg_data;
                aea_pkg::REG_UP2:   n_up[1] = i_cfg_data;
                aea_pkg::REG_LO3:   n_lo[2] = i_cfg_data;
                aea_pkg::REG_UP3:   n_up[2] = i_cfg_data;
                default: ;
            endcase
        end
        for (int d = 0; d < aea_pkg::AEA_DIMS_LIMIT; d++) begin
            n_len[d] = n_up[d] - n_lo[d] + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= aea_pkg::DIMS_RESET;
            r_esize <= aea_pkg::ESIZE_RESET;
            r_lo    <= '0;
            r_up    <= '0;
            for (int d = 0; d < aea_pkg::AEA_DIMS_LIMIT; d++) begin
                r_len[d] <= 32'd1;
            end
        end else begin
            r_dims  <= n_dims;
            r_esize <= n_esize;
            r_lo    <= n_lo;
            r_up    <= n_up;
            r_len   <= n_len;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg.dims  = r_dims;
    assign o_cfg.esize = r_esize;
    assign o_cfg.lo    = r_lo;
    assign o_cfg.len   = r_len;

endmodule

### design/aea_cell.sv
// One Horner cell: multiply the running offset by a dimension length, add a subscript.
// Depends on aea_pkg.
module aea_cell #(
    parameter int DIM = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_dims,
    input  logic [31:0]        i_len,
    input  logic               i_valid,
    input  aea_pkg::t_aea_lane i_lane,
    output logic               o_valid,
    output aea_pkg::t_aea_lane o_lane
);

    logic               r_valid;
    aea_pkg::t_aea_lane r_lane, n_lane;

    always_comb begin
        n_lane = i_lane;
        if (i_dims > 2'(DIM)) begin
            n_lane.acc = 32'(i_lane.acc * i_len) + i_lane.diff[DIM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

### design/aea_scale.sv
// Output cell: scale the offset by the element size, add the base, mask the address.
// Depends on aea_pkg.
module aea_scale #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_esize,
    input  logic                 i_valid,
    input  aea_pkg::t_aea_lane   i_lane,
    output logic                 o_valid,
    output aea_pkg::t_aea_result o_result
);

    localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic                 r_valid;
    aea_pkg::t_aea_result r_result, n_result;

    always_comb begin
        n_result.dims_mismatch = i_lane.mismatch;
        n_result.elem_addr     = '0;
        if (!i_lane.mismatch) begin
            n_result.elem_addr =
                (i_lane.base + 32'(i_lane.acc * {24'd0, i_esize})) & ADDR_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### design/array_element_address.sv
// Row-major array element address generator.
// Pipeline from start to o_valid: one entry cell, MAX_DIMS - 1 Horner cells,
// one scaling cell, each registered.
// Throughput one word per cycle; busy stays low and results cannot be held off.
// Synchronous active-low reset clears valid flags and loads descriptor defaults.
// Depends on aea_pkg, aea_cfg, aea_cell and aea_scale.
module array_element_address #(
    parameter int MAX_DIMS   = 3,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  aea_pkg::t_aea_item            i_item,
    output logic                          o_valid,
    output aea_pkg::t_aea_result          o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aea_pkg::AEA_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    aea_pkg::t_aea_cfg  w_cfg;
    aea_pkg::t_aea_lane w_lane [MAX_DIMS];
    logic [MAX_DIMS-1:0] w_valid;

    logic               r_valid;
    aea_pkg::t_aea_lane r_lane, n_lane;
    logic               w_bad_dims;

    aea_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign busy       = 1'b0;
    assign w_bad_dims = (w_cfg.dims == 2'd0) || (32'(w_cfg.dims) > 32'(MAX_DIMS));

    always_comb begin
        n_lane.base     = i_item.base_address;
        n_lane.mismatch = w_bad_dims || (i_item.subscript_count != {2'd0, w_cfg.dims});
        n_lane.diff[0]  = i_item.subscript_1 - w_cfg.lo[0];
        n_lane.diff[1]  = i_item.subscript_2 - w_cfg.lo[1];
        n_lane.diff[2]  = i_item.subscript_3 - w_cfg.lo[2];
        n_lane.acc      = n_lane.diff[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign w_valid[0] = r_valid;
    assign w_lane[0]  = r_lane;

    for (genvar g = 1; g < MAX_DIMS; g++) begin : g_cell
        aea_cell #(
            .DIM (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dims  (w_cfg.dims),
            .i_len   (w_cfg.len[g]),
            .i_valid (w_valid[g-1]),
            .i_lane  (w_lane[g-1]),
            .o_valid (w_valid[g]),
            .o_lane  (w_lane[g])
        );
    end

    aea_scale #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_esize  (w_cfg.esize),
        .i_valid  (w_valid[MAX_DIMS-1]),
        .i_lane   (w_lane[MAX_DIMS-1]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

### design/aea_checker.sv
// Port checker for the array element address block, bound to the top level.
// Depends on aea_pkg and array_element_address_assert.svh.
`include "array_element_address_assert.svh"

module aea_checker #(
    parameter int LATENCY = 4
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input aea_pkg::t_aea_result o_result,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    `AEA_ASSERT(a_word_out, i_clk, i_rst_n, (start && !busy) |-> ##LATENCY o_valid, "word lost")
    `AEA_ASSERT(a_word_in, i_clk, i_rst_n, o_valid |-> $past(start && !busy, LATENCY), "word invented")
    `AEA_NEVER(a_fault_addr, i_clk, i_rst_n, o_valid && o_result.dims_mismatch && (o_result.elem_addr != '0), "fault with nonzero address")
    `AEA_NEVER(a_cfg_stall, i_clk, i_rst_n, i_cfg_valid && !o_cfg_ready, "config write held off")

endmodule

bind array_element_address aea_checker #(
    .LATENCY (MAX_DIMS + 1)
) u_aea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_result    (o_result),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
